@@ src/quintic_trajectory_coefficients_unit_macros.svh @@
// assertion macros used by the checker
`ifndef QUINTIC_TRAJECTORY_COEFFICIENTS_UNIT_MACROS_SVH
`define QUINTIC_TRAJECTORY_COEFFICIENTS_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define QTC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qtc assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define QTC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qtc assertion failed");

`endif

@@ src/qtc_pkg.sv @@
`default_nettype none
package qtc_pkg;

	localparam int IN_FRAC_BITS_DEF  = 16;
	localparam int OUT_FRAC_BITS_DEF = 32;
	localparam int TW = 24;
	localparam int QB = 65;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SINGULAR = 2'd1,
		ST_SAT      = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [31:0] start_pos;
		logic signed [31:0] start_vel;
		logic signed [31:0] start_acc;
		logic signed [31:0] end_pos;
		logic signed [31:0] end_vel;
		logic signed [31:0] end_acc;
		logic [TW-1:0]      duration;
	} in_word_t;

	typedef struct packed {
		logic signed [63:0] coef0;
		logic signed [63:0] coef1;
		logic signed [63:0] coef2;
		logic signed [63:0] coef3;
		logic signed [63:0] coef4;
		logic signed [63:0] coef5;
		status_t            status;
	} out_word_t;

	function automatic int imax(int a, int b);
		return (a > b) ? a : b;
	endfunction

	// x * 2^k, rounded to nearest with ties away from zero when k is negative
	function automatic logic signed [63:0] scale_fix(logic signed [31:0] x, int k);
		logic [63:0] mag;
		logic [63:0] r;
		mag = x[31] ? 64'(-64'(x)) : 64'(x);
		if (k >= 0) begin
			r = mag << k;
		end else begin
			r = (mag + (64'd1 << (-k - 1))) >> (-k);
		end
		return x[31] ? $signed(64'd0 - r) : $signed(r);
	endfunction

endpackage
`default_nettype wire

@@ src/qtc_mult.sv @@
`default_nettype none
module qtc_mult import qtc_pkg::*; #(
	parameter int AW = 32
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [AW-1:0]    a,
	input  logic [TW-1:0]           t,
	output logic signed [AW+TW-1:0] p
);

	localparam int K   = (AW + TW - 1) / TW;
	localparam int EW  = K * TW;
	localparam int PPW = 2 * TW + 2;
	localparam int PW  = AW + TW;

	logic signed [EW-1:0]  ae;
	logic signed [PPW-1:0] pp_s1 [K];
	logic signed [PW-1:0]  sum;
	logic signed [PW-1:0]  p_s2;

	assign ae = EW'(a);

	// partial products, one chunk of a each
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < K; k++) begin
				if (k == K - 1) begin
					pp_s1[k] <= $signed({ae[k*TW+TW-1], ae[k*TW +: TW]}) * $signed({1'b0, t});
				end else begin
					pp_s1[k] <= $signed({1'b0, ae[k*TW +: TW]}) * $signed({1'b0, t});
				end
			end
		end
	end

	always_comb begin
		sum = '0;
		for (int k = 0; k < K; k++) begin
			sum = sum + (PW'(pp_s1[k]) <<< (k * TW));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= sum;
		end
	end

	assign p = p_s2;

endmodule
`default_nettype wire

@@ src/qtc_div.sv @@
`default_nettype none
module qtc_div import qtc_pkg::*; #(
	parameter int NW = 100,
	parameter int SH = 32,
	parameter int DW = 73
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [NW-1:0] n,
	input  logic [DW-1:0]        den,
	output logic signed [63:0]   coef,
	output logic                 sat
);

	localparam int XW = NW + SH + 1;
	localparam int HW = XW - QB;
	localparam int CW = (HW > DW) ? HW : DW;
	localparam logic [QB:0] POS_LIM = (QB+1)'(64'h7FFF_FFFF_FFFF_FFFF);
	localparam logic [QB:0] NEG_LIM = (QB+1)'(64'h8000_0000_0000_0000);

	logic [NW-1:0]  mag;
	logic [XW-1:0]  x;
	logic [HW-1:0]  top;

	logic [DW-1:0]  rem_s [QB+1];
	logic [QB-1:0]  xl_s  [QB+1];
	logic [DW-1:0]  den_s [QB+1];
	logic [QB-1:0]  q_s   [QB+1];
	logic           neg_s [QB+1];
	logic           big_s [QB+1];

	logic [QB:0]        qr;
	logic signed [63:0] coef_s;
	logic               sat_s;

	assign mag = n[NW-1] ? NW'(-n) : NW'(n);
	assign x   = XW'(mag) << (SH + 1);
	assign top = x[XW-1:QB];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DW'(top);
			xl_s[0]  <= x[QB-1:0];
			den_s[0] <= den;
			q_s[0]   <= '0;
			neg_s[0] <= n[NW-1];
			big_s[0] <= CW'(top) >= CW'(den);
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar i = 1; i <= QB; i++) begin : g_stage
		logic [DW:0] rr;
		logic        ge;
		assign rr = {rem_s[i-1], xl_s[i-1][QB-i]};
		assign ge = rr >= {1'b0, den_s[i-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? DW'(rr - {1'b0, den_s[i-1]}) : DW'(rr);
				xl_s[i]  <= xl_s[i-1];
				den_s[i] <= den_s[i-1];
				q_s[i]   <= {q_s[i-1][QB-2:0], ge};
				neg_s[i] <= neg_s[i-1];
				big_s[i] <= big_s[i-1];
			end
		end
	end

	// half-up on the doubled quotient
	assign qr = ({1'b0, q_s[QB]} + (QB+1)'(1)) >> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[QB]) begin
				if (big_s[QB] || qr > NEG_LIM) begin
					coef_s <= $signed(64'h8000_0000_0000_0000);
					sat_s  <= 1'b1;
				end else begin
					coef_s <= $signed(64'd0 - qr[63:0]);
					sat_s  <= 1'b0;
				end
			end else begin
				if (big_s[QB] || qr > POS_LIM) begin
					coef_s <= $signed(64'h7FFF_FFFF_FFFF_FFFF);
					sat_s  <= 1'b1;
				end else begin
					coef_s <= $signed(qr[63:0]);
					sat_s  <= 1'b0;
				end
			end
		end
	end

	assign coef = coef_s;
	assign sat  = sat_s;

endmodule
`default_nettype wire

@@ src/quintic_trajectory_coefficients_unit.sv @@
// Minimum-jerk quintic trajectory coefficients. Each request word carries start and end
// position, velocity and acceleration (signed, IN_FRAC_BITS fraction bits) and a duration T
// (unsigned, IN_FRAC_BITS fraction bits); the response word returns coef0..coef5 with
// OUT_FRAC_BITS fraction bits, each rounded to nearest (ties away from zero) and clamped to
// 64 bits, plus a status: ok, zero duration (coef3..coef5 forced to zero) or saturated.
// The pipeline takes one word every cycle while it is not stalled; ten stages of chunked
// multipliers build the numerators and the powers of T, and three 65-stage restoring dividers,
// one quotient bit per stage, make up most of its depth. A stalled response freezes the whole
// pipeline, so req_stall follows rsp_stall while a response is waiting.
`default_nettype none
module quintic_trajectory_coefficients_unit import qtc_pkg::*; #(
	parameter int IN_FRAC_BITS  = IN_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  in_word_t  req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_word_t rsp
);

	localparam int F      = IN_FRAC_BITS;
	localparam int O      = OUT_FRAC_BITS;
	localparam int VTW    = 32 + TW;
	localparam int TTW    = 2 * TW + 1;
	localparam int B1W    = imax(33 + F, VTW) + 1;
	localparam int ATTW   = VTW + TW;
	localparam int TTTW   = TTW + TW;
	localparam int B2TW   = 33 + TW;
	localparam int TB1W   = B1W + TW;
	localparam int B0W    = imax(imax(34 + 2 * F, VTW + F + 1), ATTW) + 2;
	localparam int T2B2W  = B2TW + TW;
	localparam int T4W    = TTTW + TW;
	localparam int T5W    = T4W + TW;
	localparam int NW     = imax(imax(B0W + 4, TB1W + 4), T2B2W + 2) + 2;
	localparam int SIDE_N = 10 + QB + 2;
	localparam int LAT    = SIDE_N + 1;

	typedef struct packed {
		logic               zero;
		logic signed [63:0] c0;
		logic signed [63:0] c1;
		logic signed [63:0] c2;
	} side_t;

	logic en;
	logic vld_s [1:LAT];

	side_t               side_s [1:SIDE_N];
	logic [TW-1:0]       t_s    [1:8];
	logic signed [32:0]  dp_s   [1:6];
	logic signed [32:0]  dv_s   [1:3];
	logic signed [32:0]  b2_s   [1:4];
	logic signed [31:0]  vs_s1;
	logic signed [31:0]  as_s1;
	logic signed [VTW-1:0] vt_s [4:6];
	logic signed [VTW-1:0] at_s4;
	logic signed [TTW-1:0] tt_s4;
	logic signed [B1W-1:0] b1_s4;
	logic signed [B0W-1:0] b0_s7;
	logic signed [B0W-1:0] b0_s8;
	logic signed [TB1W-1:0] tb1_s7;
	logic signed [TB1W-1:0] tb1_s8;
	logic signed [TTTW-1:0] ttt_s [7:9];
	logic signed [T4W-1:0]  t4_s9;
	logic signed [NW-1:0]   n3_s9, n4_s9, n5_s9;
	logic signed [NW-1:0]   n3_s10, n4_s10, n5_s10;
	logic [TTTW-1:0]        d3_s10;
	logic [T4W-1:0]         d4_s10;
	logic [T5W-1:0]         d5;
	out_word_t              out_s;

	logic signed [VTW-1:0]   vt_w, at_w;
	logic signed [TTW-1:0]   tt_w;
	logic signed [ATTW-1:0]  att_w;
	logic signed [TTTW-1:0]  ttt_w;
	logic signed [B2TW-1:0]  b2t_w;
	logic signed [TB1W-1:0]  tb1_w;
	logic signed [T2B2W-1:0] t2b2_w;
	logic signed [T4W-1:0]   t4_w;
	logic signed [T5W-1:0]   t5_w;
	logic signed [NW-1:0]    b0e, tbe, tte;
	logic signed [63:0]      c3, c4, c5;
	logic                    sat3, sat4, sat5;

	assign en        = !(rsp_valid && rsp_stall);
	assign req_stall = !en;
	assign rsp_valid = vld_s[LAT];
	assign rsp       = out_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= req_valid;
			for (int i = 2; i <= LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// front end and delay lines
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1].zero <= req.duration == '0;
			side_s[1].c0   <= scale_fix(req.start_pos, O - F);
			side_s[1].c1   <= scale_fix(req.start_vel, O - F);
			side_s[1].c2   <= scale_fix(req.start_acc, O - F - 1);
			for (int i = 2; i <= SIDE_N; i++) begin
				side_s[i] <= side_s[i-1];
			end
			t_s[1] <= req.duration;
			for (int i = 2; i <= 8; i++) begin
				t_s[i] <= t_s[i-1];
			end
			dp_s[1] <= 33'(req.end_pos) - 33'(req.start_pos);
			for (int i = 2; i <= 6; i++) begin
				dp_s[i] <= dp_s[i-1];
			end
			dv_s[1] <= 33'(req.end_vel) - 33'(req.start_vel);
			for (int i = 2; i <= 3; i++) begin
				dv_s[i] <= dv_s[i-1];
			end
			b2_s[1] <= 33'(req.end_acc) - 33'(req.start_acc);
			for (int i = 2; i <= 4; i++) begin
				b2_s[i] <= b2_s[i-1];
			end
			vs_s1 <= req.start_vel;
			as_s1 <= req.start_acc;

			vt_s[4] <= vt_w;
			vt_s[5] <= vt_s[4];
			vt_s[6] <= vt_s[5];
			at_s4   <= at_w;
			tt_s4   <= tt_w;
			b1_s4   <= (B1W'(dv_s[3]) <<< F) - B1W'(at_w);

			b0_s7  <= (B0W'(dp_s[6]) <<< (2 * F + 1)) - (B0W'(vt_s[6]) <<< (F + 1))
				- B0W'(att_w);
			tb1_s7 <= tb1_w;
			ttt_s[7] <= ttt_w;
			ttt_s[8] <= ttt_s[7];
			ttt_s[9] <= ttt_s[8];

			b0_s8  <= b0_s7;
			tb1_s8 <= tb1_s7;

			n3_s9 <= (b0e <<< 3) + (b0e <<< 1) - (tbe <<< 3) + tte;
			n4_s9 <= (tbe <<< 4) - (tbe <<< 1) - (b0e <<< 4) + b0e - (tte <<< 1);
			n5_s9 <= (b0e <<< 2) + (b0e <<< 1) - (tbe <<< 2) - (tbe <<< 1) + tte;
			t4_s9 <= t4_w;

			n3_s10 <= n3_s9;
			n4_s10 <= n4_s9;
			n5_s10 <= n5_s9;
			d3_s10 <= {ttt_s[9][TTTW-2:0], 1'b0};
			d4_s10 <= {t4_s9[T4W-2:0], 1'b0};
		end
	end

	assign b0e = NW'(b0_s8);
	assign tbe = NW'(tb1_s8);
	assign tte = NW'(t2b2_w);
	assign d5  = {t5_w[T5W-2:0], 1'b0};

	qtc_mult #(.AW(32)) u_vt (.clk(clk), .en(en), .a(vs_s1), .t(t_s[1]), .p(vt_w));
	qtc_mult #(.AW(32)) u_at (.clk(clk), .en(en), .a(as_s1), .t(t_s[1]), .p(at_w));
	qtc_mult #(.AW(TW + 1)) u_tt (
		.clk(clk), .en(en), .a($signed({1'b0, t_s[1]})), .t(t_s[1]), .p(tt_w)
	);

	qtc_mult #(.AW(VTW)) u_att (.clk(clk), .en(en), .a(at_s4), .t(t_s[4]), .p(att_w));
	qtc_mult #(.AW(TTW)) u_ttt (.clk(clk), .en(en), .a(tt_s4), .t(t_s[4]), .p(ttt_w));
	qtc_mult #(.AW(33)) u_b2t (.clk(clk), .en(en), .a(b2_s[4]), .t(t_s[4]), .p(b2t_w));
	qtc_mult #(.AW(B1W)) u_tb1 (.clk(clk), .en(en), .a(b1_s4), .t(t_s[4]), .p(tb1_w));

	qtc_mult #(.AW(B2TW)) u_t2b2 (.clk(clk), .en(en), .a(b2t_w), .t(t_s[6]), .p(t2b2_w));
	qtc_mult #(.AW(TTTW)) u_t4 (.clk(clk), .en(en), .a(ttt_w), .t(t_s[6]), .p(t4_w));

	qtc_mult #(.AW(T4W)) u_t5 (.clk(clk), .en(en), .a(t4_w), .t(t_s[8]), .p(t5_w));

	qtc_div #(.NW(NW), .SH(O), .DW(TTTW)) u_div3 (
		.clk(clk), .en(en), .n(n3_s10), .den(d3_s10), .coef(c3), .sat(sat3)
	);
	qtc_div #(.NW(NW), .SH(O + F), .DW(T4W)) u_div4 (
		.clk(clk), .en(en), .n(n4_s10), .den(d4_s10), .coef(c4), .sat(sat4)
	);
	qtc_div #(.NW(NW), .SH(O + 2 * F), .DW(T5W)) u_div5 (
		.clk(clk), .en(en), .n(n5_s10), .den(d5), .coef(c5), .sat(sat5)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			out_s.coef0 <= side_s[SIDE_N].c0;
			out_s.coef1 <= side_s[SIDE_N].c1;
			out_s.coef2 <= side_s[SIDE_N].c2;
			if (side_s[SIDE_N].zero) begin
				out_s.coef3  <= '0;
				out_s.coef4  <= '0;
				out_s.coef5  <= '0;
				out_s.status <= ST_SINGULAR;
			end else begin
				out_s.coef3  <= c3;
				out_s.coef4  <= c4;
				out_s.coef5  <= c5;
				out_s.status <= (sat3 || sat4 || sat5) ? ST_SAT : ST_OK;
			end
		end
	end

endmodule
`default_nettype wire

@@ src/qtc_checker.sv @@
`default_nettype none
`include "quintic_trajectory_coefficients_unit_macros.svh"
module qtc_checker import qtc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_stall,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input out_word_t rsp
);

	localparam logic signed [63:0] CMAX = $signed(64'h7FFF_FFFF_FFFF_FFFF);
	localparam logic signed [63:0] CMIN = $signed(64'h8000_0000_0000_0000);

	logic high_zero;
	logic any_clamped;
	logic is_singular;
	logic is_sat;

	assign high_zero   = rsp.coef3 == 64'sd0 && rsp.coef4 == 64'sd0 && rsp.coef5 == 64'sd0;
	assign any_clamped = rsp.coef3 inside {CMAX, CMIN} || rsp.coef4 inside {CMAX, CMIN}
		|| rsp.coef5 inside {CMAX, CMIN};
	assign is_singular = rsp_valid && rsp.status == ST_SINGULAR;
	assign is_sat      = rsp_valid && rsp.status == ST_SAT;

	`QTC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	`QTC_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall)

	`QTC_ASSERT_NOW(a_singular_zero, is_singular, high_zero)

	`QTC_ASSERT_NOW(a_sat_clamped, is_sat, any_clamped)

endmodule

bind quintic_trajectory_coefficients_unit qtc_checker u_qtc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import qtc_pkg::*;

	localparam int FB = 16;
	localparam int OB = 32;
	localparam int NRAND = 750;
	localparam logic signed [63:0] S64_MAX = 64'sh7FFFFFFFFFFFFFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000000000000000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	in_word_t req;
	logic rsp_valid;
	logic rsp_stall;
	out_word_t rsp;

	in_word_t pending_words[$];
	out_word_t expected_coefs[$];
	int send_idle_pct;
	int recv_idle_pct;
	int hold_cycles;
	bit stim_done;
	bit req_taken;
	int fail_count;

	quintic_trajectory_coefficients_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// round(n * 2^sh / den), ties away from zero, clamped to 64 bits
	function automatic logic signed [63:0] round_clamp(logic signed [255:0] n, int sh,
			logic signed [255:0] den, ref bit sat);
		logic signed [255:0] mag;
		logic signed [255:0] q;
		bit neg;
		neg = n < 0;
		mag = neg ? -n : n;
		q = ((mag <<< (sh + 1)) + den) / (den <<< 1);
		if (!neg && q > 256'sh7FFFFFFFFFFFFFFF) begin
			sat = 1;
			return S64_MAX;
		end
		if (neg && q > 256'sh8000000000000000) begin
			sat = 1;
			return S64_MIN;
		end
		return neg ? 64'(-q) : 64'(q);
	endfunction

	function automatic out_word_t quintic_coefs(in_word_t w);
		out_word_t r;
		bit sat;
		logic signed [255:0] ps, vs, as, pe, ve, ae, t, one;
		logic signed [255:0] b0, b1, b2, tb1, t2b2, n3, n4, n5, d3;
		sat = 0;
		ps = w.start_pos;
		vs = w.start_vel;
		as = w.start_acc;
		pe = w.end_pos;
		ve = w.end_vel;
		ae = w.end_acc;
		t = {232'd0, w.duration};
		one = 256'sd1 <<< FB;
		r.coef0 = round_clamp(ps, OB, one, sat);
		r.coef1 = round_clamp(vs, OB, one, sat);
		r.coef2 = round_clamp(as, OB, one <<< 1, sat);
		if (w.duration == 0) begin
			r.coef3 = 0;
			r.coef4 = 0;
			r.coef5 = 0;
			r.status = ST_SINGULAR;
			return r;
		end
		b0 = ((pe - ps) <<< (2 * FB + 1)) - ((vs * t) <<< (FB + 1)) - as * t * t;
		b1 = ((ve - vs) <<< FB) - as * t;
		b2 = ae - as;
		tb1 = b1 * t;
		t2b2 = b2 * t * t;
		n3 = b0 * 10 - tb1 * 8 + t2b2;
		n4 = -(b0 * 15) + tb1 * 14 - t2b2 * 2;
		n5 = b0 * 6 - tb1 * 6 + t2b2;
		d3 = 2 * t * t * t;
		r.coef3 = round_clamp(n3, OB, d3, sat);
		r.coef4 = round_clamp(n4, OB + FB, d3 * t, sat);
		r.coef5 = round_clamp(n5, OB + 2 * FB, d3 * t * t, sat);
		r.status = sat ? ST_SAT : ST_OK;
		return r;
	endfunction

	function automatic logic [31:0] rand_field();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'(int'($urandom_range(0, 131072)) - 65536);
			3: return 32'(int'($urandom_range(0, 2097152)) - 1048576);
			default: return $urandom;
		endcase
	endfunction

	function automatic in_word_t rand_word();
		in_word_t w;
		w.start_pos = rand_field();
		w.start_vel = rand_field();
		w.start_acc = rand_field();
		w.end_pos = rand_field();
		w.end_vel = rand_field();
		w.end_acc = rand_field();
		case ($urandom_range(0, 7))
			0: w.duration = 24'd0;
			1: w.duration = 24'(1 + $urandom_range(0, 15));
			2: w.duration = 24'hFFFFFF;
			3: w.duration = 24'($urandom_range(32768, 1048576));
			default: w.duration = 24'($urandom);
		endcase
		return w;
	endfunction

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else if (!req_valid || req_taken) begin
			req_taken = 1'b0;
			if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				req_valid <= 1'b1;
				req <= pending_words[0];
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// consume the word the driver saw accepted
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) begin
			expected_coefs = {expected_coefs, quintic_coefs(req)};
			void'(pending_words.pop_front());
			req_taken = 1'b1;
		end
	end

	// receiver stall
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (hold_cycles > 0) begin
			rsp_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_coefs.size() == 0) begin
				$error("unexpected word: %h", rsp);
				fail_count++;
			end else begin
				e = expected_coefs.pop_front();
				if (rsp.coef0 !== e.coef0) begin
					$error("coef0 exp %h got %h", e.coef0, rsp.coef0);
					fail_count++;
				end
				if (rsp.coef1 !== e.coef1) begin
					$error("coef1 exp %h got %h", e.coef1, rsp.coef1);
					fail_count++;
				end
				if (rsp.coef2 !== e.coef2) begin
					$error("coef2 exp %h got %h", e.coef2, rsp.coef2);
					fail_count++;
				end
				if (rsp.coef3 !== e.coef3) begin
					$error("coef3 exp %h got %h", e.coef3, rsp.coef3);
					fail_count++;
				end
				if (rsp.coef4 !== e.coef4) begin
					$error("coef4 exp %h got %h", e.coef4, rsp.coef4);
					fail_count++;
				end
				if (rsp.coef5 !== e.coef5) begin
					$error("coef5 exp %h got %h", e.coef5, rsp.coef5);
					fail_count++;
				end
				if (rsp.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, rsp.status);
					fail_count++;
				end
			end
		end
	end

	initial begin
		in_word_t w;
		int k;
		arst_n = 1'b0;
		send_idle_pct = 13;
		recv_idle_pct = 80;
		hold_cycles = 0;
		stim_done = 0;
		req_taken = 1'b0;
		fail_count = 0;
		repeat (7) @(posedge clk);
		arst_n = 1'b1;

		// directed words
		w = '0;
		w.duration = 24'h010000;
		pending_words = {pending_words, w};
		w.duration = 24'd0;
		pending_words = {pending_words, w};
		w.start_pos = 32'h7FFFFFFF;
		w.start_vel = 32'h80000000;
		w.start_acc = 32'h7FFFFFFF;
		pending_words = {pending_words, w};
		w.start_acc = 32'h80000000;
		w.duration = 24'd1;
		w.end_pos = 32'h80000000;
		w.end_vel = 32'h7FFFFFFF;
		w.end_acc = 32'h80000000;
		pending_words = {pending_words, w};
		w.duration = 24'hFFFFFF;
		pending_words = {pending_words, w};
		w = '1;
		pending_words = {pending_words, w};
		w.start_pos = 32'sd65536;
		w.start_vel = 32'sd32768;
		w.start_acc = -32'sd65536;
		w.end_pos = 32'sd655360;
		w.end_vel = 32'sd0;
		w.end_acc = 32'sd1;
		w.duration = 24'h020000;
		pending_words = {pending_words, w};
		w.duration = 24'h000100;
		pending_words = {pending_words, w};
		w.start_pos = 32'sd3;
		w.start_acc = 32'sd1;
		w.duration = 24'h030000;
		pending_words = {pending_words, w};
		for (k = 0; k < 10; k++) pending_words = {pending_words, rand_word()};

		for (k = 0; k < NRAND; k++) begin
			pending_words = {pending_words, rand_word()};
			if (k == NRAND / 3) begin
				wait (pending_words.size() == 0);
				send_idle_pct = 80;
				recv_idle_pct = 13;
			end else if (k == 2 * NRAND / 3) begin
				wait (pending_words.size() == 0);
				send_idle_pct = 0;
				recv_idle_pct = 0;
				@(negedge clk);
				hold_cycles = 300;
			end
		end
		wait (pending_words.size() == 0);
		wait (expected_coefs.size() == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && expected_coefs.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

endmodule
